// ----- design/bcuckoo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcuckoo_pkg;

    // Field and register widths.
    localparam int KEY_W = 32;
    localparam int CNT_W = 9;
    localparam int SEL_W = 2;
    localparam int CFG_IDX_W = 2;

    // Default sizes of the store.
    localparam int MAX_BUCKETS_DEF = 256;
    localparam int MAX_SLOTS_DEF = 256;
    localparam int WAYS_DEF = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [KEY_W-1:0] SEED_RST = 32'd0;
    localparam logic [CNT_W-1:0] BUCKETS_RST = 9'd245;
    localparam logic [CNT_W-1:0] SLOTS_RST = 9'd192;

    // Hash modulus and the fold constant 2^21 mod the modulus.
    localparam logic [KEY_W-1:0] HASH_PRIME = 32'd1900813;
    localparam int FOLD_SHIFT = 21;
    localparam logic [KEY_W-1:0] FOLD_K = 32'((64'd1 << FOLD_SHIFT) - 64'(HASH_PRIME));
    localparam int FOLD_STEPS = 4;

    // Shared remainder unit: bits retired per cycle and steps per 32-bit dividend.
    localparam int REM_BITS = 4;
    localparam int REM_STEPS = KEY_W / REM_BITS;

    // Empty marker of a store entry.
    localparam logic [KEY_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    // Input item and result item.
    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
        logic [SEL_W-1:0] table_select;
    } t_in_item;

    typedef struct packed {
        logic found;
        logic written;
    } t_out_item;

    // Fixed additive constant of each way.
    function automatic logic [KEY_W-1:0] way_c0(input logic [SEL_W-1:0] way);
        logic [KEY_W-1:0] c;
        case (way)
            2'd0: c = 32'd69;
            2'd1: c = 32'd6969;
            2'd2: c = 32'd696969;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

    // Fixed multiplicative constant of each way.
    function automatic logic [KEY_W-1:0] way_c1(input logic [SEL_W-1:0] way);
        logic [KEY_W-1:0] c;
        case (way)
            2'd0: c = 32'd696;
            2'd1: c = 32'd69696;
            2'd2: c = 32'd6969696;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/bucketed_three_way_cuckoo_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_item  (func, key, table_select)
// result    out        o_out_valid / i_out_stall  o_out_item (found, written)
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A key other than all ones is hashed and looked up before its result is given; the
// reserved key goes straight to its result. The time is set by the shared remainder unit
// (4 bits a cycle, run once for the bucket and once per way) and by the single read
// port of the store, which reads the three ways one after another.
// After reset a clearing pass writes all ones to each of the
// MAX_BUCKETS*WAYS*MAX_SLOTS entries, one a cycle, before the first item is taken.
// A result waits in the output register while the next item is already accepted.

module bucketed_three_way_cuckoo_insert #(
    parameter int MAX_BUCKETS = bcuckoo_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_SLOTS = bcuckoo_pkg::MAX_SLOTS_DEF,
    parameter int WAYS = bcuckoo_pkg::WAYS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire bcuckoo_pkg::t_in_item                  i_in_item,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output bcuckoo_pkg::t_out_item                      o_out_item,
    input  wire logic                                   i_cfg_we,
    input  wire logic [bcuckoo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bcuckoo_pkg::KEY_W-1:0]          i_cfg_data
);
    import bcuckoo_pkg::*;

    localparam int DEPTH = MAX_BUCKETS * WAYS * MAX_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SLT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int STEP_W = $clog2(REM_STEPS);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_BMOD  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_FOLD  = 4'd5;
    localparam logic [3:0] S_FIX   = 4'd6;
    localparam logic [3:0] S_SMOD  = 4'd7;
    localparam logic [3:0] S_ADDR  = 4'd8;
    localparam logic [3:0] S_READ  = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;
    localparam logic [3:0] S_WRITE = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]        r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [KEY_W-1:0]  r_seed;
    logic [CNT_W-1:0]  r_bkt_cnt;
    logic [CNT_W-1:0]  r_slt_cnt;
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [SEL_W-1:0]  r_sel;
    logic [SEL_W-1:0]  r_way;
    logic [STEP_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [KEY_W-1:0]  r_x;
    logic [BKT_W-1:0]  r_bucket;
    logic [SLT_W-1:0]  r_slot;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [KEY_W-1:0]  r_rdata;
    logic              r_found;
    logic              r_written;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic [KEY_W-1:0]  r_store [DEPTH];

    logic [CNT_W-1:0]  w_bkt_div;
    logic [CNT_W-1:0]  w_slt_div;
    logic [CNT_W-1:0]  w_div;
    logic [CNT_W:0]    w_rem_t;
    logic [CNT_W-1:0]  n_rem;
    logic [KEY_W-1:0]  n_dvd;
    logic [KEY_W-1:0]  n_fold;
    logic [ADDR_W-1:0] w_row;
    logic [ADDR_W-1:0] w_addr;
    logic [KEY_W-1:0]  w_c0;
    logic [KEY_W-1:0]  w_c1;
    logic              w_ins_ok;
    logic              w_out_free;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [KEY_W-1:0]  w_mem_wdata;

    // Divisors in use: zero acts as one, too large acts as the maximum.
    always_comb begin
        if (r_bkt_cnt == '0) begin
            w_bkt_div = CNT_W'(1);
        end else if (32'(r_bkt_cnt) > MAX_BUCKETS) begin
            w_bkt_div = CNT_W'(MAX_BUCKETS);
        end else begin
            w_bkt_div = r_bkt_cnt;
        end
        if (r_slt_cnt == '0) begin
            w_slt_div = CNT_W'(1);
        end else if (32'(r_slt_cnt) > MAX_SLOTS) begin
            w_slt_div = CNT_W'(MAX_SLOTS);
        end else begin
            w_slt_div = r_slt_cnt;
        end
    end

    assign w_div = (r_state == S_BMOD) ? w_bkt_div : w_slt_div;

    // Shared remainder unit: four restoring steps per cycle, MSB first.
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        w_rem_t = '0;
        for (int i = 0; i < REM_BITS; i++) begin
            w_rem_t = {n_rem, n_dvd[KEY_W-1]};
            n_dvd = {n_dvd[KEY_W-2:0], 1'b0};
            if (w_rem_t >= {1'b0, w_div}) begin
                n_rem = CNT_W'(w_rem_t - {1'b0, w_div});
            end else begin
                n_rem = w_rem_t[CNT_W-1:0];
            end
        end
    end

    // One fold of the hash sum: high part times 2^21 mod the prime, plus the low part.
    assign n_fold = 32'(r_x[KEY_W-1:FOLD_SHIFT]) * FOLD_K + 32'(r_x[FOLD_SHIFT-1:0]);

    // Hash coefficients of the current way.
    assign w_c0 = way_c0(r_way) ^ r_seed;
    assign w_c1 = way_c1(r_way) ^ r_seed;

    // Store address of the current way's slot.
    assign w_row = ADDR_W'(r_bucket) * ADDR_W'(WAYS) + ADDR_W'(r_way);
    assign w_addr = w_row * ADDR_W'(MAX_SLOTS) + ADDR_W'(r_slot);

    // An insert writes when the key is missing and the subtable exists.
    assign w_ins_ok = !r_found && !r_func && (32'(r_sel) < WAYS);

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Store write port: the clearing pass, or the insert.
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_mem_we = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = EMPTY_WORD;
        end else begin
            w_mem_we = (r_state == S_WRITE) && w_ins_ok;
            w_mem_waddr = r_wr_addr;
            w_mem_wdata = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_waddr] <= w_mem_wdata;
        end
    end

    // Store read port, registered output.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_store[r_rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RST;
            r_bkt_cnt <= BUCKETS_RST;
            r_slt_cnt <= SLOTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEED: r_seed <= i_cfg_data;
                REG_BUCKETS: r_bkt_cnt <= i_cfg_data[CNT_W-1:0];
                REG_SLOTS: r_slt_cnt <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills when a result is ready and empties when taken.
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_in_item.key == EMPTY_WORD) ? S_DONE : S_BMOD;
                    end
                end
                S_BMOD: begin
                    if (r_cnt == STEP_W'(REM_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_FOLD;
                S_FOLD: begin
                    if (r_cnt == STEP_W'(FOLD_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: r_state <= S_SMOD;
                S_SMOD: begin
                    if (r_cnt == STEP_W'(REM_STEPS - 1)) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: r_state <= S_READ;
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    r_state <= (32'(r_way) == WAYS - 1) ? S_WRITE : S_MUL;
                end
                S_WRITE: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_func <= i_in_item.func;
                r_key <= i_in_item.key;
                r_sel <= i_in_item.table_select;
                r_dvd <= i_in_item.key;
                r_rem <= '0;
                r_cnt <= '0;
                r_way <= '0;
                r_found <= 1'b0;
                r_written <= 1'b0;
            end
            S_BMOD: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + STEP_W'(1);
                r_bucket <= BKT_W'(n_rem);
            end
            S_MUL: r_x <= w_c1 * r_key;
            S_SUM: begin
                r_x <= r_x + w_c0;
                r_cnt <= '0;
            end
            S_FOLD: begin
                r_x <= n_fold;
                r_cnt <= r_cnt + STEP_W'(1);
            end
            S_FIX: begin
                r_dvd <= (r_x >= HASH_PRIME) ? r_x - HASH_PRIME : r_x;
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_SMOD: begin
                r_dvd <= n_dvd;
                r_rem <= n_rem;
                r_cnt <= r_cnt + STEP_W'(1);
                r_slot <= SLT_W'(n_rem);
            end
            S_ADDR: begin
                r_rd_addr <= w_addr;
                if (r_way == r_sel) begin
                    r_wr_addr <= w_addr;
                end
            end
            S_CMP: begin
                if (r_rdata == r_key) begin
                    r_found <= 1'b1;
                end
                r_way <= r_way + SEL_W'(1);
            end
            S_WRITE: r_written <= w_ins_ok;
            S_DONE: begin
                if (w_out_free) begin
                    r_out_item.found <= r_found;
                    r_out_item.written <= r_written;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

endmodule

`default_nettype wire

// ----- dv/cuckoo_checker.sv -----
`timescale 1ns / 1ps

module cuckoo_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  bcuckoo_pkg::t_in_item               i_in_item,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  bcuckoo_pkg::t_out_item              i_out_item,
    input  logic                                i_cfg_we,
    input  logic [bcuckoo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bcuckoo_pkg::KEY_W-1:0]       i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked,
    output int                                  o_found_seen,
    output int                                  o_written_seen
);

    localparam int BUCKET_LIMIT = bcuckoo_pkg::MAX_BUCKETS_DEF;
    localparam int SLOT_LIMIT = bcuckoo_pkg::MAX_SLOTS_DEF;
    localparam int WAY_COUNT = bcuckoo_pkg::WAYS_DEF;
    localparam logic FUNC_INSERT = 1'b0;

    // Per-way hash constants, way 0 in the low word.
    localparam logic [95:0] WAY_ADD = {32'd696969, 32'd6969, 32'd69};
    localparam logic [95:0] WAY_MUL = {32'd6969696, 32'd69696, 32'd696};

    typedef struct packed {
        bcuckoo_pkg::t_out_item    outcome;
        logic [31:0]               key;
    } t_awaited;

    // Shadow copy of the registers and of the slot store; absent entries are empty.
    logic [31:0] cfg_seed;
    logic [8:0]  cfg_buckets;
    logic [8:0]  cfg_slots;
    logic [31:0] slot_image [int];
    t_awaited    awaited_outcomes [$];

    int mismatch_count = 0;
    int results_checked = 0;
    int found_seen = 0;
    int written_seen = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Looks the key up in its three slots and places it on an insert miss, as the block does.
    function automatic bcuckoo_pkg::t_out_item probe_and_place(bcuckoo_pkg::t_in_item item);
        logic [31:0] buckets;
        logic [31:0] slots;
        logic [31:0] bucket;
        logic [31:0] offset;
        logic [31:0] mult;
        logic [31:0] mixed;
        logic [31:0] held;
        int          idx [WAY_COUNT];
        bcuckoo_pkg::t_out_item res;

        res = '0;
        // A zero divisor acts as one and an oversized one is clamped.
        buckets = (cfg_buckets == 0) ? 32'd1 :
                  (cfg_buckets > BUCKET_LIMIT) ? BUCKET_LIMIT : 32'(cfg_buckets);
        slots = (cfg_slots == 0) ? 32'd1 :
                (cfg_slots > SLOT_LIMIT) ? SLOT_LIMIT : 32'(cfg_slots);
        if (item.key != bcuckoo_pkg::EMPTY_WORD) begin
            bucket = item.key % buckets;
            for (int w = 0; w < WAY_COUNT; w++) begin
                offset = WAY_ADD[32*w +: 32] ^ cfg_seed;
                mult = WAY_MUL[32*w +: 32] ^ cfg_seed;
                mixed = offset + mult * item.key;
                idx[w] = (int'(bucket) * WAY_COUNT + w) * SLOT_LIMIT
                         + int'((mixed % bcuckoo_pkg::HASH_PRIME) % slots);
                held = slot_image.exists(idx[w]) ? slot_image[idx[w]]
                                                 : bcuckoo_pkg::EMPTY_WORD;
                if (held == item.key) begin
                    res.found = 1'b1;
                end
            end
            // An insert miss evicts whatever sat in the selected subtable.
            if (!res.found && item.func == FUNC_INSERT && item.table_select < WAY_COUNT) begin
                slot_image[idx[item.table_select]] = item.key;
                res.written = 1'b1;
            end
        end
        return res;
    endfunction

    // Results are retired before new items are predicted, so one edge keeps its order.
    always @(posedge i_clk) begin : watch
        t_awaited want;
        t_awaited fresh;

        if (!i_rst_n) begin
            cfg_seed = bcuckoo_pkg::SEED_RST;
            cfg_buckets = bcuckoo_pkg::BUCKETS_RST;
            cfg_slots = bcuckoo_pkg::SLOTS_RST;
            slot_image.delete();
            awaited_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bcuckoo_pkg::REG_SEED:    cfg_seed = i_cfg_data;
                    bcuckoo_pkg::REG_BUCKETS: cfg_buckets = i_cfg_data[8:0];
                    bcuckoo_pkg::REG_SLOTS:   cfg_slots = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result item arrived with no item outstanding");
                end else begin
                    want = awaited_outcomes.pop_front();
                    results_checked++;
                    if (want.outcome.found) found_seen++;
                    if (want.outcome.written) written_seen++;
                    if (i_out_item.found !== want.outcome.found) begin
                        report_mismatch($sformatf("key %h: found %b, expected %b",
                            want.key, i_out_item.found, want.outcome.found));
                    end
                    if (i_out_item.written !== want.outcome.written) begin
                        report_mismatch($sformatf("key %h: written %b, expected %b",
                            want.key, i_out_item.written, want.outcome.written));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh.key = i_in_item.key;
                fresh.outcome = probe_and_place(i_in_item);
                awaited_outcomes.insert(awaited_outcomes.size(), fresh);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending <= awaited_outcomes.size();
        o_checked <= results_checked;
        o_found_seen <= found_seen;
        o_written_seen <= written_seen;
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;
    localparam int RANDOM_PER_PHASE = 185;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTINGS_USED = 7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    bcuckoo_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    bcuckoo_pkg::t_out_item out_item;
    logic cfg_we = 1'b0;
    logic [bcuckoo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bcuckoo_pkg::KEY_W-1:0] cfg_data = '0;
    logic calm = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int found_seen;
    int written_seen;
    int cycle_count = 0;
    logic [31:0] recent_keys [$];

    bucketed_three_way_cuckoo_insert dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cuckoo_checker cuckoo_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_item     (out_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_found_seen   (found_seen),
        .o_written_seen (written_seen)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The limit covers the clearing pass after reset with a wide margin.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("tb failed");
            $finish;
        end
    end

    // The result side stalls about a fifth of the time, except in the calm stretch.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // Offers one item, sometimes after a gap, and holds it until it is taken.
    task automatic send_item(input logic func, input logic [31:0] key, input logic [1:0] sel);
        int gap;

        if (!calm && $urandom_range(0, 99) < 20) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 70) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{func: func, key: key, table_select: sel};
        do @(posedge clk); while (in_stall);
    endtask

    // Stops offering items until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges with the enable held high.
    task automatic set_config(input logic [31:0] seed, input logic [31:0] buckets,
                              input logic [31:0] slots);
        cfg_we <= 1'b1;
        cfg_index <= bcuckoo_pkg::REG_SEED;
        cfg_data <= seed;
        @(posedge clk);
        cfg_index <= bcuckoo_pkg::REG_BUCKETS;
        cfg_data <= buckets;
        @(posedge clk);
        cfg_index <= bcuckoo_pkg::REG_SLOTS;
        cfg_data <= slots;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Often reuses recent keys so that inserts are later found and evicted.
    task automatic next_random_item(output bcuckoo_pkg::t_in_item it);
        int pick;
        int depth;

        pick = $urandom_range(0, 99);
        if (pick < 45 && recent_keys.size() > 0) begin
            depth = (recent_keys.size() > 48) ? 48 : recent_keys.size();
            it.key = recent_keys[recent_keys.size() - 1 - $urandom_range(0, depth - 1)];
        end else if (pick < 52) begin
            it.key = bcuckoo_pkg::EMPTY_WORD;
        end else if (pick < 60) begin
            case ($urandom_range(0, 3))
                0: it.key = 32'h0000_0000;
                1: it.key = 32'hFFFF_FFFE;
                2: it.key = 32'd1 << $urandom_range(0, 31);
                default: it.key = ~(32'd1 << $urandom_range(0, 31));
            endcase
        end else begin
            it.key = $urandom;
        end
        it.func = ($urandom_range(0, 99) < 65) ? FUNC_INSERT : FUNC_LOOKUP;
        it.table_select = ($urandom_range(0, 99) < 10) ? 2'd3 : 2'($urandom_range(0, 2));
        if (it.key != bcuckoo_pkg::EMPTY_WORD) begin
            recent_keys.insert(recent_keys.size(), it.key);
            if (recent_keys.size() > 256) void'(recent_keys.pop_front());
        end
    endtask

    initial begin
        bcuckoo_pkg::t_in_item it;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset configuration.
        send_item(FUNC_INSERT, 32'h0000_0000, 2'd0);
        send_item(FUNC_LOOKUP, 32'h0000_0000, 2'd0);
        send_item(FUNC_INSERT, 32'h0000_0000, 2'd1);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 2'd0);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 2'd3);
        send_item(FUNC_INSERT, 32'hFFFF_FFFE, 2'd2);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 2'd1);
        send_item(FUNC_INSERT, 32'd12345, 2'd3);
        send_item(FUNC_LOOKUP, 32'd12345, 2'd0);
        send_item(FUNC_LOOKUP, 32'hA5A5_A5A5, 2'd3);
        send_item(FUNC_INSERT, 32'h8000_0000, 2'd1);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF, 2'd2);
        send_item(FUNC_INSERT, 32'd245, 2'd0);
        send_item(FUNC_INSERT, 32'd490, 2'd0);
        send_item(FUNC_LOOKUP, 32'd245, 2'd2);
        send_item(FUNC_LOOKUP, 32'd490, 2'd1);

        // Each phase changes the divisors without clearing the store.
        for (int phase = 1; phase < SETTINGS_USED; phase++) begin
            drain_results();
            calm <= (phase == 2);
            case (phase)
                1: set_config($urandom, 32'd1, 32'd1);
                2: set_config(32'hFFFF_FFFF, 32'd256, 32'd256);
                3: set_config(32'h0000_0000, 32'd0, 32'd511);
                4: set_config($urandom, 32'd511, 32'd0);
                5: set_config($urandom, $urandom_range(2, 8), $urandom_range(2, 8));
                default: set_config($urandom, $urandom, $urandom);
            endcase
            if (phase == 1) begin
                // One slot per way: a second insert evicts the first; old keys are looked up again.
                send_item(FUNC_LOOKUP, 32'h0000_0000, 2'd0);
                send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 2'd0);
                send_item(FUNC_INSERT, 32'd1, 2'd0);
                send_item(FUNC_INSERT, 32'd2, 2'd0);
                send_item(FUNC_LOOKUP, 32'd1, 2'd0);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                next_random_item(it);
                send_item(it.func, it.key, it.table_select);
                if (phase == 5 && n == RANDOM_PER_PHASE / 2) drain_results();
            end
        end

        drain_results();
        repeat (80) @(posedge clk);
        $display("Checked %0d result items over %0d register settings.", checked,
                 SETTINGS_USED);
        $display("Keys found: %0d, keys written: %0d, mismatches: %0d.", found_seen,
                 written_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
